### rtl/core/r34_pkg.sv
package r34_pkg;

    localparam int unsigned RADIX       = 34;
    localparam int unsigned STORE_DEPTH = 7;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned DIGIT_W     = 6;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned LEN_W       = 3;

    localparam logic [VALUE_W-1:0] RECIP     = 32'hF0F0_F0F1;
    localparam int unsigned        RECIP_SH  = 37;
    localparam int unsigned        QUOT_W    = 2 * VALUE_W - RECIP_SH;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                load;
        logic [VALUE_W-1:0]  dividend;
    } div_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  quot;
        logic [DIGIT_W-1:0]  rem;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] j;
        logic [CHAR_W-1:0] c;
        j = CHAR_W'(d) - CHAR_W'(10);
        c = CHAR_A + j;
        if (j >= CHAR_W'(8))
            c = c + CHAR_W'(1);
        if (j >= CHAR_W'(13))
            c = c + CHAR_W'(1);
        if (d < DIGIT_W'(10))
            c = CHAR_ZERO + CHAR_W'(d);
        if (d >= DIGIT_W'(RADIX))
            c = CHAR_ZERO;
        return c;
    endfunction

endpackage

### rtl/core/r34_div_unit.sv
module r34_div_unit
(
    input  logic               clk,
    input  r34_pkg::div_req_t  req,
    output r34_pkg::div_rsp_t  rsp
);

    logic [r34_pkg::QUOT_W-1:0]    quot_reg;
    logic [r34_pkg::QUOT_W-1:0]    quot_next;
    logic [r34_pkg::VALUE_W-1:0]   dvd_reg;
    logic [2*r34_pkg::VALUE_W-1:0] prod;
    logic [r34_pkg::VALUE_W-1:0]   quot_full;
    logic [r34_pkg::VALUE_W-1:0]   back;
    logic [r34_pkg::VALUE_W-1:0]   rem_full;

    // multiply by reciprocal of the radix, exact for every 32-bit dividend
    assign prod      = (2*r34_pkg::VALUE_W)'(req.dividend)
                     * (2*r34_pkg::VALUE_W)'(r34_pkg::RECIP);
    assign quot_next = prod[2*r34_pkg::VALUE_W-1:r34_pkg::RECIP_SH];

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            quot_reg <= quot_next;
            dvd_reg  <= req.dividend;
        end
    end

    assign quot_full = r34_pkg::VALUE_W'(quot_reg);
    assign back      = (quot_full << 5) + (quot_full << 1);
    assign rem_full  = dvd_reg - back;

    assign rsp.quot = quot_full;
    assign rsp.rem  = rem_full[r34_pkg::DIGIT_W-1:0];

endmodule

### rtl/core/radix34_digit_encoder.sv
// Radix-34 encoder: takes a 32-bit value and a minimum length (saturated to the
// digit limit), and sends its digits as ASCII characters from 0-9 and A-Z
// without I and O, most significant first, one character per output beat,
// with last_char set on the final one. A value with D radix-34 digits padded to
// N characters (N >= D) passes through the divide-by-34 unit once per digit (one
// reciprocal multiply, then the remainder), then its N characters are loaded
// one by one into the output register, each waiting while the output stalls.
// The input stays stalled from acceptance until the last character is loaded
// into the output register; the next value is accepted while that character
// still waits to be taken.
module radix34_digit_encoder
#(
    parameter int unsigned MAX_DIGITS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] number,
    input  logic [2:0]  min_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  digit_char,
    output logic        last_char
);

    localparam int unsigned LIM   = (MAX_DIGITS > r34_pkg::STORE_DEPTH) ? r34_pkg::STORE_DEPTH :
                                    (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    localparam int unsigned CNT_W = $clog2(LIM + 1);
    localparam int unsigned IDX_W = (LIM > 1) ? $clog2(LIM) : 1;

    r34_pkg::state_t state_reg;
    r34_pkg::state_t state_next;

    logic [r34_pkg::VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]            want_reg;
    logic [CNT_W-1:0]            ndiv_reg;
    logic [CNT_W-1:0]            total_reg;
    logic [CNT_W-1:0]            emit_reg;
    logic [r34_pkg::DIGIT_W-1:0] store_reg [LIM];
    logic                        out_valid_reg;
    logic [r34_pkg::CHAR_W-1:0]  out_char_reg;
    logic                        out_last_reg;

    r34_pkg::div_req_t div_req;
    r34_pkg::div_rsp_t div_rsp;

    logic                        accept;
    logic                        slot_free;
    logic                        load_out;
    logic [CNT_W-1:0]            ndiv_inc;
    logic                        more_digits;
    logic [CNT_W-1:0]            want_sat;
    logic [r34_pkg::CHAR_W-1:0]  emit_char;

    r34_div_unit u_div
    (
        .clk (clk),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign accept      = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign ndiv_inc    = ndiv_reg + CNT_W'(1);
    assign more_digits = (div_rsp.quot != '0) && (ndiv_inc < CNT_W'(LIM));
    assign want_sat    = ({1'b0, min_length} > 4'(LIM)) ? CNT_W'(LIM) : CNT_W'(min_length);
    assign emit_char   = (emit_reg >= ndiv_reg) ? r34_pkg::CHAR_ZERO
                       : r34_pkg::glyph_of(store_reg[emit_reg[IDX_W-1:0]]);

    assign div_req.dividend = val_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            r34_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = r34_pkg::S_MUL;
            end
            r34_pkg::S_MUL:
            begin
                state_next = r34_pkg::S_DIG;
            end
            r34_pkg::S_DIG:
            begin
                state_next = more_digits ? r34_pkg::S_MUL : r34_pkg::S_EMIT;
            end
            r34_pkg::S_EMIT:
            begin
                if (slot_free && (emit_reg == '0))
                    state_next = r34_pkg::S_IDLE;
            end
            default:
            begin
                state_next = r34_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        div_req.load = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            r34_pkg::S_IDLE: in_stall     = 1'b0;
            r34_pkg::S_MUL:  div_req.load = 1'b1;
            r34_pkg::S_DIG:  load_out     = 1'b0;
            r34_pkg::S_EMIT: load_out     = slot_free;
            default:         in_stall     = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= r34_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            ndiv_reg      <= '0;
            total_reg     <= '0;
            emit_reg      <= '0;
            want_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                want_reg <= want_sat;
                ndiv_reg <= '0;
            end
            if (state_reg == r34_pkg::S_DIG)
            begin
                ndiv_reg <= ndiv_inc;
                if (!more_digits)
                begin
                    total_reg <= (want_reg > ndiv_inc) ? want_reg : ndiv_inc;
                    emit_reg  <= ((want_reg > ndiv_inc) ? want_reg : ndiv_inc) - CNT_W'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                emit_reg      <= emit_reg - CNT_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            val_reg <= number;
        if (state_reg == r34_pkg::S_DIG)
        begin
            val_reg                         <= div_rsp.quot;
            store_reg[ndiv_reg[IDX_W-1:0]]  <= div_rsp.rem;
        end
        if (load_out)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= (emit_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = out_char_reg;
    assign last_char  = out_last_reg;

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == r34_pkg::S_MUL)
        else $error("accepted value did not start the divide");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= 7'd48) && (digit_char <= 7'd90))
        else $error("character outside the alphabet");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == r34_pkg::S_EMIT |-> (ndiv_reg != '0) && (total_reg >= ndiv_reg))
        else $error("emitting without a divided digit");

    a_last_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (emit_reg == '0) |=> (state_reg == r34_pkg::S_IDLE) && last_char)
        else $error("last character did not end the string");

    a_no_mid_string_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == r34_pkg::S_EMIT) |-> in_stall)
        else $error("input taken while emitting");

endmodule
